### design/farthest_first_k_center_macros.svh
// Assertion helpers used by the top module of the k-center selector.
// Each one is clocked on i_clk and switched off while i_rst_n is low.
`ifndef FARTHEST_FIRST_K_CENTER_MACROS_SVH
`define FARTHEST_FIRST_K_CENTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFKC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFKC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ffkc_pkg.sv
`timescale 1ns / 1ps
package ffkc_pkg;
    localparam int MAX_POINTS  = 1024;
    localparam int MAX_CENTERS = 16;
    localparam int COORD_BITS  = 12;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PLC_W  = $clog2(MAX_CENTERS + 1);
    localparam int DIST_W = 2 * COORD_BITS + 1;

    localparam int IDX_W     = 10;
    localparam int XY_W      = 12;
    localparam int RAD_W     = 13;
    localparam int CC_W      = 5;
    localparam int SP_W      = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam int SQ_TOP   = 2 * ((DIST_W - 1) / 2);
    localparam int SQ_STEPS = SQ_TOP / 2 + 1;
    localparam int SQ_CNT_W = $clog2(SQ_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CENTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POINT = 1'b1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_CAPT,
        S_PASS,
        S_DECIDE,
        S_EMIT,
        S_SQRT,
        S_LAST
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]     idx;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DIST_W-1:0]     old;
    } t_pt_tag;

    typedef struct packed {
        logic vld;
        logic busy;
    } t_dist_st;
endpackage

### design/ffkc_if.sv
`timescale 1ns / 1ps
interface ffkc_pt_if import ffkc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [XY_W-1:0] coord_x;
    logic [XY_W-1:0] coord_y;
    logic            is_last;

    modport source (output valid, output coord_x, output coord_y, output is_last,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input is_last,
                    output ready);
endinterface

interface ffkc_ctr_if import ffkc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] center_index;
    logic [XY_W-1:0]  center_x;
    logic [XY_W-1:0]  center_y;
    logic [RAD_W-1:0] cover_radius;
    logic             final_res;

    modport source (output valid, output center_index, output center_x, output center_y,
                    output cover_radius, output final_res, input ready);
    modport sink   (input valid, input center_index, input center_x, input center_y,
                    input cover_radius, input final_res, output ready);
endinterface

### design/ffkc_ram.sv
`timescale 1ns / 1ps
module ffkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/ffkc_dist.sv
`timescale 1ns / 1ps
module ffkc_dist import ffkc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  t_pt_tag               i_tag,
    input  logic [COORD_BITS-1:0] i_cx,
    input  logic [COORD_BITS-1:0] i_cy,
    output t_dist_st              o_st,
    output t_pt_tag               o_tag,
    output logic [DIST_W-1:0]     o_sq
);
    logic                    r_vld1, r_vld2, r_vld3;
    t_pt_tag                 r_tag1, r_tag2, r_tag3;
    logic [COORD_BITS-1:0]   r_dx1, r_dy1;
    logic [2*COORD_BITS-1:0] r_sx2, r_sy2;
    logic [DIST_W-1:0]       r_sq3;
    logic [COORD_BITS-1:0]   w_dx, w_dy;
    logic [2*COORD_BITS-1:0] w_sx, w_sy;

    always_comb begin
        w_dx = (i_tag.x >= i_cx) ? (i_tag.x - i_cx) : (i_cx - i_tag.x);
        w_dy = (i_tag.y >= i_cy) ? (i_tag.y - i_cy) : (i_cy - i_tag.y);
        w_sx = r_dx1 * r_dx1;
        w_sy = r_dy1 * r_dy1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1 <= i_tag;
        r_dx1  <= w_dx;
        r_dy1  <= w_dy;
        r_tag2 <= r_tag1;
        r_sx2  <= w_sx;
        r_sy2  <= w_sy;
        r_tag3 <= r_tag2;
        r_sq3  <= DIST_W'(r_sx2) + DIST_W'(r_sy2);
    end

    assign o_st.vld  = r_vld3;
    assign o_st.busy = r_vld1 | r_vld2 | r_vld3;
    assign o_tag     = r_tag3;
    assign o_sq      = r_sq3;
endmodule

### design/ffkc_isqrt.sv
`timescale 1ns / 1ps
module ffkc_isqrt import ffkc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIST_W-1:0] i_val,
    output logic              o_busy,
    output logic [DIST_W-1:0] o_root
);
    logic [SQ_CNT_W-1:0] r_cnt;
    logic [DIST_W-1:0]   r_v, r_res, r_bit;
    logic [DIST_W-1:0]   w_trial;
    logic                w_ge;

    always_comb begin
        w_trial = r_res + r_bit;
        w_ge    = r_v >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= SQ_CNT_W'(SQ_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= DIST_W'(1) << SQ_TOP;
        end else if (r_cnt != '0) begin
            if (w_ge) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_root = r_res;
endmodule

### design/farthest_first_k_center.sv
`timescale 1ns / 1ps
// Channel  Port   Direction  Word
// points   i_pt   in         coord_x, coord_y, is_last
// centers  o_ctr  out        center_index, center_x, center_y, cover_radius, final_res
// config   i_cfg  in         num_centers (index 0), start_point (index 1)
//
// A point that is not the last is accepted and the block stays ready for more points.
// The last point starts selection: a fetch and a capture state read the first center, then each
// center takes a pass through the shared distance pipeline over the n stored points and a
// decision state, plus an emit state for every center but the last; the square root state
// and a final state close the run. Emit and final states stall while a word waits.
// Reset is synchronous and active low; the point memories need no clearing.
`include "farthest_first_k_center_macros.svh"
module farthest_first_k_center import ffkc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ffkc_pt_if.sink              i_pt,
    ffkc_ctr_if.source           o_ctr,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);
    t_state                r_state, n_state;
    logic [CC_W-1:0]       r_num_centers;
    logic [SP_W-1:0]       r_start_point;
    logic [CNT_W-1:0]      r_count;
    logic [PLC_W-1:0]      r_k, r_placed;
    logic [CNT_W-1:0]      r_iss;
    logic                  r_first;
    logic                  r_rd_vld;
    logic [ADDR_W-1:0]     r_rd_idx;
    logic [ADDR_W-1:0]     r_pend_idx;
    logic [COORD_BITS-1:0] r_pend_x, r_pend_y;
    logic [DIST_W-1:0]     r_best;
    logic [ADDR_W-1:0]     r_best_idx;
    logic [COORD_BITS-1:0] r_best_x, r_best_y;
    logic                  r_out_vld;
    logic [IDX_W-1:0]      r_out_idx;
    logic [XY_W-1:0]       r_out_x, r_out_y;
    logic [RAD_W-1:0]      r_out_rad;
    logic                  r_out_final;

    logic                  w_in_ready, w_in_acc, w_store;
    logic [CNT_W-1:0]      w_n_new;
    logic [ADDR_W-1:0]     w_cur;
    logic [PLC_W-1:0]      w_k;
    logic                  w_out_free;
    logic                  w_issue, w_pass_done, w_stop;
    logic                  w_sel_live;
    logic                  w_capt, w_emit, w_last_res, w_out_load, w_sq_start;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [COORD_BITS-1:0] w_x_rdata, w_y_rdata;
    logic [DIST_W-1:0]     w_d_rdata;
    logic                  w_dist_we;
    logic [DIST_W-1:0]     w_new_d;
    t_pt_tag               w_tag_in, w_tag_out;
    t_dist_st              w_dist_st;
    logic [DIST_W-1:0]     w_sq;
    logic                  w_sq_busy;
    logic [DIST_W-1:0]     w_root;

    always_comb begin
        w_in_acc    = i_pt.valid && w_in_ready;
        w_store     = w_in_acc && (r_count < CNT_W'(MAX_POINTS));
        w_n_new     = r_count + CNT_W'(w_store);
        w_cur       = (32'(r_start_point) < 32'(w_n_new)) ? ADDR_W'(r_start_point) : '0;
        if (r_num_centers == '0) begin
            w_k = PLC_W'(1);
        end else if (32'(r_num_centers) > MAX_CENTERS) begin
            w_k = PLC_W'(MAX_CENTERS);
        end else begin
            w_k = PLC_W'(r_num_centers);
        end
        w_out_free  = !r_out_vld || o_ctr.ready;
        w_issue     = (r_state == S_PASS) && (r_iss < r_count);
        w_pass_done = !(r_iss < r_count) && !r_rd_vld && !w_dist_st.busy;
        w_stop      = (r_placed >= r_k) || (r_best == '0);
        w_sel_live  = (r_state != S_LOAD) && (r_state != S_FETCH) && (r_state != S_CAPT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc && i_pt.is_last) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_CAPT;
            S_CAPT:  n_state = S_PASS;
            S_PASS: begin
                if (w_pass_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = w_stop ? S_SQRT : S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_PASS;
                end
            end
            S_SQRT: begin
                if (!w_sq_busy) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (w_out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_capt     = 1'b0;
        w_emit     = 1'b0;
        w_last_res = 1'b0;
        w_sq_start = 1'b0;
        w_rd_addr  = ADDR_W'(r_iss);
        case (r_state)
            S_LOAD:   w_in_ready = 1'b1;
            S_FETCH:  w_rd_addr  = r_pend_idx;
            S_CAPT:   w_capt     = 1'b1;
            S_DECIDE: w_sq_start = w_stop;
            S_EMIT:   w_emit     = w_out_free;
            S_LAST:   w_last_res = w_out_free;
            default: begin
            end
        endcase
        w_out_load = w_emit || w_last_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_num_centers <= CC_W'(1);
            r_start_point <= '0;
            r_count       <= '0;
            r_k           <= PLC_W'(1);
            r_placed      <= '0;
            r_iss         <= '0;
            r_first       <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_CENTERS: r_num_centers <= CC_W'(i_cfg_wdata);
                    CFG_START_POINT: r_start_point <= SP_W'(i_cfg_wdata);
                    default: begin
                    end
                endcase
            end
            if (w_in_acc) begin
                r_count <= w_n_new;
                if (i_pt.is_last) begin
                    r_k <= w_k;
                end
            end else if (w_last_res) begin
                r_count <= '0;
            end
            if (w_capt) begin
                r_placed <= PLC_W'(1);
                r_first  <= 1'b1;
                r_iss    <= '0;
            end else if (w_emit) begin
                r_placed <= r_placed + 1'b1;
                r_first  <= 1'b0;
                r_iss    <= '0;
            end else if (w_issue) begin
                r_iss <= r_iss + 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_ctr.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= ADDR_W'(r_iss);
        if (w_in_acc && i_pt.is_last) begin
            r_pend_idx <= w_cur;
        end
        if (w_capt) begin
            r_pend_x <= w_x_rdata;
            r_pend_y <= w_y_rdata;
            r_best   <= '0;
        end else if (w_emit) begin
            r_pend_idx <= r_best_idx;
            r_pend_x   <= r_best_x;
            r_pend_y   <= r_best_y;
            r_best     <= '0;
        end else if (w_dist_we && (w_new_d > r_best)) begin
            r_best     <= w_new_d;
            r_best_idx <= w_tag_out.idx;
            r_best_x   <= w_tag_out.x;
            r_best_y   <= w_tag_out.y;
        end
        if (w_out_load) begin
            r_out_idx   <= IDX_W'(r_pend_idx);
            r_out_x     <= XY_W'(r_pend_x);
            r_out_y     <= XY_W'(r_pend_y);
            r_out_rad   <= w_last_res ? RAD_W'(w_root) : '0;
            r_out_final <= w_last_res;
        end
    end

    ffkc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_x_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (ADDR_W'(r_count)),
        .i_wdata (COORD_BITS'(i_pt.coord_x)),
        .i_raddr (w_rd_addr),
        .o_rdata (w_x_rdata)
    );

    ffkc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_y_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (ADDR_W'(r_count)),
        .i_wdata (COORD_BITS'(i_pt.coord_y)),
        .i_raddr (w_rd_addr),
        .o_rdata (w_y_rdata)
    );

    // The first pass of a run overwrites every entry, so stale distances are never used.
    assign w_dist_we = w_dist_st.vld;
    assign w_new_d   = (r_first || (w_sq < w_tag_out.old)) ? w_sq : w_tag_out.old;

    ffkc_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_dist_store (
        .i_clk   (i_clk),
        .i_we    (w_dist_we),
        .i_waddr (w_tag_out.idx),
        .i_wdata (w_new_d),
        .i_raddr (w_rd_addr),
        .o_rdata (w_d_rdata)
    );

    always_comb begin
        w_tag_in.idx = r_rd_idx;
        w_tag_in.x   = w_x_rdata;
        w_tag_in.y   = w_y_rdata;
        w_tag_in.old = w_d_rdata;
    end

    ffkc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_tag   (w_tag_in),
        .i_cx    (r_pend_x),
        .i_cy    (r_pend_y),
        .o_st    (w_dist_st),
        .o_tag   (w_tag_out),
        .o_sq    (w_sq)
    );

    ffkc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_best),
        .o_busy  (w_sq_busy),
        .o_root  (w_root)
    );

    assign i_pt.ready         = w_in_ready;
    assign o_ctr.valid        = r_out_vld;
    assign o_ctr.center_index = r_out_idx;
    assign o_ctr.center_x     = r_out_x;
    assign o_ctr.center_y     = r_out_y;
    assign o_ctr.cover_radius = r_out_rad;
    assign o_ctr.final_res    = r_out_final;

    `FFKC_ASSERT_NOW(a_placed_within_k, w_sel_live, r_placed <= r_k, "Too many centers placed.")
    `FFKC_ASSERT_NOW(a_dist_write_in_pass, w_dist_we, r_state == S_PASS, "Distance written outside a pass.")
    `FFKC_ASSERT_NEXT(a_final_ends_run, w_last_res, (r_count == '0) && r_out_vld && r_out_final, "Final word did not close the run.")
    `FFKC_ASSERT_NOW(a_mid_radius_zero, o_ctr.valid && !o_ctr.final_res, o_ctr.cover_radius == '0, "Radius set on a word that is not final.")
endmodule
